@@ hw/rtl/pafp_pkg.sv @@
// Shared types, codes and constants for the partition allocator.
`default_nettype none
package pafp_pkg;

  localparam int DEF_MAX_PARTITIONS = 64;
  localparam int DEF_MEMORY_UNITS   = 65536;

  localparam int SIZE_W = 17;
  localparam int ADDR_W = 16;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 3;
  localparam int CMD_W  = 2;
  localparam int POL_W  = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  busy;
    size_t size;
    addr_t base;
  } entry_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [POL_W-1:0] {
    POL_FIRST  = 2'd0,
    POL_NEXT   = 2'd1,
    POL_BEST   = 2'd2,
    POL_FIRST2 = 2'd3
  } policy_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_BADSIZE  = 3'd2,
    ST_BADINDEX = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EDIT,
    S_DONE
  } state_t;

  // How entries past the edited position move during a rewrite pass
  typedef enum logic [1:0] {
    SH_KEEP,
    SH_INS,
    SH_DEL1,
    SH_DEL2
  } shift_t;

  typedef struct packed {
    shift_t shift;
    entry_t val;
    entry_t rem;
  } edit_t;

  function automatic size_t sat_add(size_t a, size_t b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pafp_cell.sv @@
// One table entry of the partition chain; shifts toward the head on demand.
`default_nettype none
module pafp_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire pafp_pkg::entry_t din,
  output pafp_pkg::entry_t     dout
);
  import pafp_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= din;
    end
  end

  assign dout = ent_r;

endmodule
`default_nettype wire

@@ hw/rtl/pafp_editor.sv @@
// Stream rewriter that feeds the chain tail: passes, replaces, inserts or drops entries.
`default_nettype none
module pafp_editor #(
  parameter int PW = 7,
  parameter int IW = 6
) (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire logic             pass_through,
  input  wire logic [PW-1:0]    pos,
  input  wire logic [IW-1:0]    x,
  input  wire pafp_pkg::edit_t  ed,
  input  wire pafp_pkg::entry_t head,
  output pafp_pkg::entry_t      feed
);
  import pafp_pkg::*;

  // w1..w3 hold the three most recent heads shifted out, newest in w1
  entry_t w1_r, w2_r, w3_r;
  logic [PW-1:0] q, xe;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      w1_r <= head;
      w2_r <= w1_r;
      w3_r <= w2_r;
    end
  end

  assign q  = pos - PW'(2);
  assign xe = PW'(x);

  always_comb begin
    feed = head;
    if (!pass_through && pos >= PW'(2)) begin
      if (q < xe) begin
        feed = w2_r;
      end else if (q == xe) begin
        feed = ed.val;
      end else begin
        case (ed.shift)
          SH_KEEP: feed = w2_r;
          SH_INS:  feed = (q == xe + PW'(1)) ? ed.rem : w3_r;
          SH_DEL1: feed = w1_r;
          SH_DEL2: feed = head;
          default: feed = w2_r;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/partition_allocator_fit_policies.sv @@
// Top level: command sequencer, fit search and the chain of partition cells.
`default_nettype none
// Partition allocator keeping a table of up to MAX_PARTITIONS partitions in a
// chain of cells that rotates through the head cell. One command is handled at a
// time. Load makes one rewrite pass; allocate and release make a read rotation,
// a decide step and a rewrite pass; an allocation refused after the search ends
// after the decide step; commands rejected on decode go straight to the result.
// The result waits in an output register until taken; the next command is
// accepted once the result has been handed to that register.
// fit_policy must be written only while the block is idle; the block does not
// enforce this.
module partition_allocator_fit_policies #(
  parameter int MAX_PARTITIONS = pafp_pkg::DEF_MAX_PARTITIONS,
  parameter int MEMORY_UNITS   = pafp_pkg::DEF_MEMORY_UNITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // size_value[16:0], load_address[32:17], partition_index[38:33], zero pad
  input  wire logic [pafp_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  wire logic [pafp_pkg::CMD_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status[2:0], base_address[18:3], result_index[24:19], zero pad
  output logic [pafp_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pafp_pkg::POL_W-1:0]      cfg_wr_data
);
  import pafp_pkg::*;

  localparam int IW = $clog2(MAX_PARTITIONS);
  localparam int CW = $clog2(MAX_PARTITIONS + 1);
  localparam int PW = $clog2(MAX_PARTITIONS + 2);

  // ---------------- registers ----------------
  state_t          state_r, state_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   cursor_r, cursor_nxt;
  logic [IW-1:0]   start_r, start_nxt;
  policy_t         policy_r;
  cmd_t            cmd_r, cmd_nxt;
  size_t           req_r, req_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   f_r, f_nxt;
  entry_t          fe_r, fe_nxt;
  logic            alt_found_r, alt_found_nxt;
  logic [IW-1:0]   alt_r, alt_nxt;
  entry_t          alte_r, alte_nxt;
  entry_t          prev_r, prev_nxt, cur_r, cur_nxt, nxt_r, nxt_nxt;
  logic [IW-1:0]   x_r, x_nxt;
  edit_t           ed_r, ed_nxt;
  status_t         rs_status_r, rs_status_nxt;
  addr_t           rs_base_r, rs_base_nxt;
  logic [IW-1:0]   rs_idx_r, rs_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // ---------------- input decode ----------------
  size_t            in_size;
  addr_t            in_addr;
  logic [IDX_W-1:0] in_pidx;
  cmd_t             in_cmd;
  logic             in_fire;
  logic             size_bad, load_bad;

  assign in_size = in_tdata[SIZE_W-1:0];
  assign in_addr = in_tdata[SIZE_W+ADDR_W-1:SIZE_W];
  assign in_pidx = in_tdata[SIZE_W+ADDR_W+IDX_W-1:SIZE_W+ADDR_W];
  assign in_cmd  = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign size_bad = (in_size == '0) || (32'(in_size) > 32'(MEMORY_UNITS));
  assign load_bad = size_bad || (32'(in_addr) + 32'(in_size) > 32'(MEMORY_UNITS));

  // ---------------- chain of cells ----------------
  entry_t cell_q [MAX_PARTITIONS];
  entry_t head, feed;
  logic   shift_en, pass_through;

  assign shift_en     = (state_r == S_SCAN) || (state_r == S_EDIT);
  assign pass_through = (state_r != S_EDIT);
  assign head         = cell_q[0];

  for (genvar k = 0; k < MAX_PARTITIONS; k++) begin : g_cell
    entry_t din;
    if (k == MAX_PARTITIONS - 1) begin : g_tail
      assign din = feed;
    end else begin : g_mid
      assign din = cell_q[k+1];
    end
    pafp_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (din),
      .dout     (cell_q[k])
    );
  end

  pafp_editor #(.PW(PW), .IW(IW)) u_editor (
    .clk          (clk),
    .shift_en     (shift_en),
    .pass_through (pass_through),
    .pos          (pos_r),
    .x            (x_r),
    .ed           (ed_r),
    .head         (head),
    .feed         (feed)
  );

  // ---------------- decide logic ----------------
  logic          sel_found;
  logic [IW-1:0] sel_f;
  entry_t        sel_e;
  logic          exact;
  logic [IW-1:0] ri;
  logic          m_left, m_right, has_next;
  addr_t         base_j;
  size_t         size_j, size_fin;
  logic [IW-1:0] rel_j;
  logic [IW-1:0] rel_cursor;
  logic [CW-1:0] rel_count;
  logic          go_edit;

  function automatic logic [IW-1:0] fix_cursor(logic [IW-1:0] c, logic [CW-1:0] n);
    return (32'(c) >= 32'(n)) ? '0 : c;
  endfunction

  always_comb begin
    logic [IW-1:0] cc;
    logic [CW-1:0] cn;
    logic [IW-1:0] r;
    r         = '0;
    sel_found = found_r;
    sel_f     = f_r;
    sel_e     = fe_r;
    if (policy_r == POL_NEXT && !found_r) begin
      sel_found = alt_found_r;
      sel_f     = alt_r;
      sel_e     = alte_r;
    end
    exact = (sel_e.size == req_r);

    ri       = IW'(pidx_r);
    m_left   = (ri != '0) && !prev_r.busy &&
               ({2'b0, prev_r.base} + {1'b0, prev_r.size} == {2'b0, cur_r.base});
    base_j   = m_left ? prev_r.base : cur_r.base;
    size_j   = m_left ? sat_add(prev_r.size, cur_r.size) : cur_r.size;
    has_next = (32'(ri) + 32'd1 < 32'(count_r));
    m_right  = has_next && !nxt_r.busy &&
               ({2'b0, base_j} + {1'b0, size_j} == {2'b0, nxt_r.base});
    size_fin = m_right ? sat_add(size_j, nxt_r.size) : size_j;
    rel_j    = m_left ? ri - IW'(1) : ri;

    // follow the cursor through each removal
    cc = cursor_r;
    cn = count_r;
    if (m_left) begin
      if (cc > ri) cc = cc - IW'(1);
      cn = cn - CW'(1);
      cc = fix_cursor(cc, cn);
    end
    if (m_right) begin
      r = m_left ? ri : ri + IW'(1);
      if (cc > r) cc = cc - IW'(1);
      cn = cn - CW'(1);
      cc = fix_cursor(cc, cn);
    end
    rel_cursor = cc;
    rel_count  = cn;

    if (cmd_r == CMD_ALLOC) begin
      go_edit = sel_found && (exact || 32'(count_r) < 32'(MAX_PARTITIONS));
    end else begin
      go_edit = 1'b1;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_LOAD: begin
              state_nxt = (load_bad || 32'(count_r) >= 32'(MAX_PARTITIONS)) ?
                          S_DONE : S_EDIT;
            end
            CMD_ALLOC:   state_nxt = size_bad ? S_DONE : S_SCAN;
            CMD_RELEASE: state_nxt = (32'(in_pidx) >= 32'(count_r)) ? S_DONE : S_SCAN;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN:   if (pos_r == PW'(MAX_PARTITIONS - 1)) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = go_edit ? S_EDIT : S_DONE;
      S_EDIT:   if (pos_r == PW'(MAX_PARTITIONS + 1)) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    logic cand;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    start_nxt     = start_r;
    cmd_nxt       = cmd_r;
    req_nxt       = req_r;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    f_nxt         = f_r;
    fe_nxt        = fe_r;
    alt_found_nxt = alt_found_r;
    alt_nxt       = alt_r;
    alte_nxt      = alte_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    x_nxt         = x_r;
    ed_nxt        = ed_r;
    rs_status_nxt = rs_status_r;
    rs_base_nxt   = rs_base_r;
    rs_idx_nxt    = rs_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cand = 1'b0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_cmd;
          req_nxt       = in_size;
          pidx_nxt      = in_pidx;
          pos_nxt       = '0;
          found_nxt     = 1'b0;
          alt_found_nxt = 1'b0;
          start_nxt     = fix_cursor(cursor_r, count_r);
          rs_status_nxt = ST_OK;
          rs_base_nxt   = '0;
          rs_idx_nxt    = '0;
          case (in_cmd)
            CMD_LOAD: begin
              if (load_bad) begin
                rs_status_nxt = ST_BADSIZE;
              end else if (32'(count_r) >= 32'(MAX_PARTITIONS)) begin
                rs_status_nxt = ST_FULL;
              end else begin
                x_nxt        = IW'(count_r);
                ed_nxt.shift = SH_KEEP;
                ed_nxt.val   = '{busy: 1'b0, size: in_size, base: in_addr};
                ed_nxt.rem   = '{busy: 1'b0, size: in_size, base: in_addr};
                count_nxt    = count_r + CW'(1);
                rs_base_nxt  = in_addr;
                rs_idx_nxt   = IW'(count_r);
              end
            end
            CMD_ALLOC: begin
              if (size_bad) rs_status_nxt = ST_BADSIZE;
            end
            CMD_RELEASE: begin
              if (32'(in_pidx) >= 32'(count_r)) rs_status_nxt = ST_BADINDEX;
            end
            default: rs_status_nxt = ST_BADINDEX;
          endcase
        end
      end

      S_SCAN: begin
        pos_nxt = pos_r + PW'(1);
        cand = (32'(pos_r) < 32'(count_r)) && !head.busy && (head.size >= req_r);
        case (policy_r)
          POL_NEXT: begin
            if (cand && !found_r && 32'(pos_r) >= 32'(start_r)) begin
              found_nxt = 1'b1;
              f_nxt     = IW'(pos_r);
              fe_nxt    = head;
            end
            if (cand && !alt_found_r) begin
              alt_found_nxt = 1'b1;
              alt_nxt       = IW'(pos_r);
              alte_nxt      = head;
            end
          end
          POL_BEST: begin
            if (cand && (!found_r || head.size < fe_r.size)) begin
              found_nxt = 1'b1;
              f_nxt     = IW'(pos_r);
              fe_nxt    = head;
            end
          end
          default: begin
            if (cand && !found_r) begin
              found_nxt = 1'b1;
              f_nxt     = IW'(pos_r);
              fe_nxt    = head;
            end
          end
        endcase
        // capture the released entry and its neighbors
        if (pos_r == PW'(pidx_r) - PW'(1)) prev_nxt = head;
        if (pos_r == PW'(pidx_r))          cur_nxt  = head;
        if (pos_r == PW'(pidx_r) + PW'(1)) nxt_nxt  = head;
      end

      S_DECIDE: begin
        pos_nxt = '0;
        if (cmd_r == CMD_ALLOC) begin
          if (!sel_found) begin
            rs_status_nxt = ST_NOFIT;
          end else if (exact) begin
            x_nxt        = sel_f;
            ed_nxt.shift = SH_KEEP;
            ed_nxt.val   = '{busy: 1'b1, size: req_r, base: sel_e.base};
            ed_nxt.rem   = sel_e;
            cursor_nxt   = fix_cursor(sel_f + IW'(1), count_r);
            rs_base_nxt  = sel_e.base;
            rs_idx_nxt   = sel_f;
          end else if (32'(count_r) >= 32'(MAX_PARTITIONS)) begin
            rs_status_nxt = ST_FULL;
          end else begin
            x_nxt        = sel_f;
            ed_nxt.shift = SH_INS;
            ed_nxt.val   = '{busy: 1'b1, size: req_r, base: sel_e.base};
            ed_nxt.rem   = '{busy: 1'b0, size: sel_e.size - req_r,
                             base: sel_e.base + ADDR_W'(req_r)};
            count_nxt    = count_r + CW'(1);
            cursor_nxt   = sel_f + IW'(1);
            rs_base_nxt  = sel_e.base;
            rs_idx_nxt   = sel_f;
          end
        end else begin
          x_nxt        = rel_j;
          ed_nxt.val   = '{busy: 1'b0, size: size_fin, base: base_j};
          ed_nxt.rem   = ed_nxt.val;
          ed_nxt.shift = (m_left && m_right) ? SH_DEL2 :
                         (m_left || m_right) ? SH_DEL1 : SH_KEEP;
          count_nxt    = rel_count;
          cursor_nxt   = rel_cursor;
          rs_base_nxt  = base_j;
          rs_idx_nxt   = rel_j;
        end
      end

      S_EDIT: begin
        pos_nxt = pos_r + PW'(1);
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({IDX_W'(rs_idx_r), rs_base_r, rs_status_r});
        end
      end

      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      policy_r    <= POL_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) policy_r <= policy_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    start_r     <= start_nxt;
    cmd_r       <= cmd_nxt;
    req_r       <= req_nxt;
    pidx_r      <= pidx_nxt;
    found_r     <= found_nxt;
    f_r         <= f_nxt;
    fe_r        <= fe_nxt;
    alt_found_r <= alt_found_nxt;
    alt_r       <= alt_nxt;
    alte_r      <= alte_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    nxt_r       <= nxt_nxt;
    x_r         <= x_nxt;
    ed_r        <= ed_nxt;
    rs_status_r <= rs_status_nxt;
    rs_base_r   <= rs_base_nxt;
    rs_idx_r    <= rs_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ tb/sv/partition_allocator_fit_policies_tb.sv @@
// Self-checking testbench for the partition allocator: commands in, status, base and index checked.
`default_nettype none
module partition_allocator_fit_policies_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pafp_pkg::*;

  localparam int NPART = DEF_MAX_PARTITIONS;
  localparam int MEMU  = DEF_MEMORY_UNITS;
  localparam int SIZE_MAX17 = 32'h1FFFF;
  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  typedef struct packed {
    cmd_t             cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  pidx;
  } cmd_item_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] base;
    logic [IDX_W-1:0]  idx;
  } reply_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_wr_en;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [CMD_W-1:0] in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [POL_W-1:0] cfg_wr_data;

  partition_allocator_fit_policies uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state
  logic [ADDR_W-1:0] tbl_base[NPART];
  int unsigned       tbl_size[NPART];
  bit                tbl_busy[NPART];
  int unsigned       tbl_count, cursor;
  policy_t           policy;

  cmd_item_t pending_cmds[$];
  reply_t    expected_replies[$];
  int        errors;
  longint    cycles;
  bit        hold_off_req;
  int        stall_left;
  int        in_gap;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void drop_entry(int unsigned r);
    for (int unsigned j = r; j + 1 < tbl_count; j++) begin
      tbl_base[j] = tbl_base[j+1];
      tbl_size[j] = tbl_size[j+1];
      tbl_busy[j] = tbl_busy[j+1];
    end
    tbl_count--;
    if (cursor > r) cursor--;
    if (cursor >= tbl_count) cursor = 0;
  endfunction

  function automatic int unsigned search_fit(int unsigned req);
    int unsigned i, start, found;
    found = tbl_count;
    if (policy == POL_NEXT) begin
      start = cursor < tbl_count ? cursor : 0;
      for (int unsigned k = 0; k < tbl_count; k++) begin
        i = start + k;
        if (i >= tbl_count) i -= tbl_count;
        if (!tbl_busy[i] && tbl_size[i] >= req) return i;
      end
      return tbl_count;
    end
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i] || tbl_size[i] < req) continue;
      if (policy != POL_BEST) return i;
      if (found == tbl_count || tbl_size[i] < tbl_size[found]) found = i;
    end
    return found;
  endfunction

  function automatic reply_t predict_reply(cmd_item_t c);
    reply_t r;
    int unsigned sz, f, i, ob, os;
    r = '{ST_OK, '0, '0};
    sz = c.size;
    case (c.cmd)
      CMD_LOAD: begin
        if (sz == 0 || sz > MEMU || int'(c.addr) + sz > MEMU) r.status = ST_BADSIZE;
        else if (tbl_count >= NPART) r.status = ST_FULL;
        else begin
          tbl_base[tbl_count] = c.addr;
          tbl_size[tbl_count] = sz;
          tbl_busy[tbl_count] = 0;
          r.idx = IDX_W'(tbl_count);
          r.base = c.addr;
          tbl_count++;
        end
      end
      CMD_ALLOC: begin
        f = 0;
        if (sz == 0 || sz > MEMU) r.status = ST_BADSIZE;
        else begin
          f = search_fit(sz);
          if (f >= tbl_count) r.status = ST_NOFIT;
          else if (tbl_size[f] == sz) begin
            tbl_busy[f] = 1;
            r.base = tbl_base[f];
            r.idx = IDX_W'(f);
            cursor = f + 1;
            if (cursor >= tbl_count) cursor = 0;
          end else if (tbl_count >= NPART) r.status = ST_FULL;
          else begin
            ob = tbl_base[f];
            os = tbl_size[f];
            for (int j = int'(tbl_count); j > int'(f); j--) begin
              tbl_base[j] = tbl_base[j-1];
              tbl_size[j] = tbl_size[j-1];
              tbl_busy[j] = tbl_busy[j-1];
            end
            tbl_count++;
            tbl_size[f] = sz;
            tbl_busy[f] = 1;
            tbl_base[f+1] = ADDR_W'(ob + sz);
            tbl_size[f+1] = os - sz;
            tbl_busy[f+1] = 0;
            cursor = f + 1;
            r.base = ADDR_W'(ob);
            r.idx = IDX_W'(f);
          end
        end
      end
      CMD_RELEASE: begin
        if (c.pidx >= tbl_count) r.status = ST_BADINDEX;
        else begin
          i = c.pidx;
          tbl_busy[i] = 0;
          if (i > 0 && !tbl_busy[i-1] && tbl_base[i-1] + tbl_size[i-1] == tbl_base[i]) begin
            tbl_size[i-1] = tbl_size[i-1] + tbl_size[i] > SIZE_MAX17 ?
                            SIZE_MAX17 : tbl_size[i-1] + tbl_size[i];
            drop_entry(i);
            i--;
          end
          if (i + 1 < tbl_count && !tbl_busy[i+1] &&
              tbl_base[i] + tbl_size[i] == tbl_base[i+1]) begin
            tbl_size[i] = tbl_size[i] + tbl_size[i+1] > SIZE_MAX17 ?
                          SIZE_MAX17 : tbl_size[i] + tbl_size[i+1];
            drop_entry(i + 1);
          end
          r.base = tbl_base[i];
          r.idx = IDX_W'(i);
        end
      end
      default: r.status = ST_BADINDEX;
    endcase
    if (r.status != ST_OK) begin
      r.base = '0;
      r.idx = '0;
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: feeds items from the pending queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(predict_reply(pending_cmds.pop_front()));
      end
      if ((!in_tvalid || in_tready) && pending_cmds.size() > 0 &&
          (in_gap == 0 || hold_off_req)) begin
        in_tvalid <= 1;
        in_tuser <= pending_cmds[0].cmd;
        in_tdata <= {1'b0, pending_cmds[0].pidx, pending_cmds[0].addr, pending_cmds[0].size};
        in_gap <= $urandom_range(0, 9) < 7 ? 0 :
                  ($urandom_range(0, 19) == 0 ? int'($urandom_range(20, 200)) :
                                                int'($urandom_range(1, 4)));
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst_n) begin
      out_tready <= 0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{status_t'(out_tdata[2:0]), out_tdata[18:3], out_tdata[24:19]};
        if (expected_replies.size() == 0) report("result with nothing expected");
        else begin
          want = expected_replies.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d want %0d", got.status, want.status));
          if (got.base != want.base)
            report($sformatf("base %0h want %0h", got.base, want.base));
          if (got.idx != want.idx)
            report($sformatf("index %0d want %0d", got.idx, want.idx));
        end
      end
      if (hold_off_req) begin
        out_tready <= 0;
        stall_left <= 2000;
      end else if (stall_left > 0) begin
        out_tready <= 0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        out_tready <= 0;
        stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(50, 400) : $urandom_range(1, 6);
      end else begin
        out_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic cmd_item_t mk(cmd_t c, int unsigned sz, int unsigned ad, int unsigned px);
    cmd_item_t it;
    it.cmd = c;
    it.size = SIZE_W'(sz);
    it.addr = ADDR_W'(ad);
    it.pidx = IDX_W'(px);
    return it;
  endfunction

  // Random well-formed workload with some noise
  function automatic cmd_item_t rand_item();
    int unsigned r, sz, ad;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      sz = $urandom_range(0, 7) == 0 ? $urandom_range(0, SIZE_MAX17) : $urandom_range(1, 4096);
      ad = $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 15) * 4096;
      return mk(CMD_LOAD, sz, ad, $urandom_range(0, 63));
    end else if (r < 65) begin
      sz = $urandom_range(0, 9) == 0 ? $urandom_range(0, SIZE_MAX17) : $urandom_range(1, 2048);
      return mk(CMD_ALLOC, sz, $urandom_range(0, 65535), $urandom_range(0, 63));
    end else if (r < 97) begin
      return mk(CMD_RELEASE, $urandom_range(0, SIZE_MAX17), $urandom_range(0, 65535),
                $urandom_range(0, 63));
    end
    return mk(CMD_UNUSED, $urandom_range(0, SIZE_MAX17), $urandom_range(0, 65535),
              $urandom_range(0, 63));
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_replies.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_policy(policy_t p);
    cfg_wr_en <= 1;
    cfg_wr_data <= p;
    policy = p;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off_req = 0;
    rst_n = 0;
    in_tdata = '0;
    in_tuser = '0;
    in_tvalid = 0;
    out_tready = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    tbl_count = 0;
    cursor = 0;
    policy = POL_FIRST;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: bad sizes, exact fit, split, merges, bad index, unknown command
    pending_cmds.push_back(mk(CMD_ALLOC, 10, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, SIZE_MAX17, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 2, 65535, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 65536, 0, 63));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 65536, 0, 0));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 100, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 200, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 65537, 0, 0));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 63));
    pending_cmds.push_back(mk(CMD_UNUSED, SIZE_MAX17, 65535, 63));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
    drain();

    // Fill the table, then a load, an exact fit and a refused split on a full table
    set_policy(POL_BEST);
    for (int k = 0; k < NPART; k++) pending_cmds.push_back(mk(CMD_LOAD, 2 + k % 3, k * 8, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 1, 60000, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 3, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 1, 0, 0));
    drain();

    // Random phases across all policies; the first one holds off the receiver
    for (int ph = 0; ph < 8; ph++) begin
      set_policy(policy_t'(ph % 4));
      if (ph == 0) begin
        hold_off_req <= 1;
        for (int k = 0; k < 20; k++) pending_cmds.push_back(rand_item());
        @(posedge clk);
        hold_off_req <= 0;
      end
      for (int k = 0; k < 150; k++) begin
        // keep the table from saturating by now and then queueing a burst of releases of index 0
        if ($urandom_range(0, 299) == 0)
          for (int j = 0; j < 70; j++) pending_cmds.push_back(mk(CMD_RELEASE, 0, 0, 0));
        pending_cmds.push_back(rand_item());
      end
      drain();
    end

    if (expected_replies.size() > 0) report("results still expected");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

@@ partition_allocator_fit_policies.f @@
hw/rtl/pafp_pkg.sv
hw/rtl/pafp_cell.sv
hw/rtl/pafp_editor.sv
hw/rtl/partition_allocator_fit_policies.sv
tb/sv/partition_allocator_fit_policies_tb.sv
